// ===== sv/ohm_pkg.sv =====
// shared types and constants for the ordered bucket hash map
package ohm_pkg;

  localparam int BucketW   = 8;
  localparam int NumBuckets = 256;
  localparam int HashMul   = 17;
  localparam int LabelW    = 64;
  localparam int LenW      = 4;
  localparam int ValW      = 4;
  localparam int ValMax    = 15;
  localparam int TotalOutW = 24;
  localparam int InDataW   = 72;
  localparam int InUserW   = 1;
  localparam int OutDataW  = 32;
  localparam int OutUserW  = 3;

  typedef enum logic [2:0] {
    StAppended   = 3'd0,
    StUpdated    = 3'd1,
    StRemoved    = 3'd2,
    StNotFound   = 3'd3,
    StBucketFull = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    FuncRemove = 1'b0,
    FuncInsert = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    SIdle,
    SHash,
    SCount,
    SScan,
    SFinish,
    SScale,
    SDone
  } state_e;

endpackage

// ===== sv/ohm_hash.sv =====
// byte-serial label hash, one character per cycle
module ohm_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ohm_pkg::LabelW-1:0]   chars_i,
  input  logic [ohm_pkg::LenW-1:0]     len_i,
  output logic                         done_o,
  output logic [ohm_pkg::BucketW-1:0]  hash_o
);
  import ohm_pkg::*;

  logic                 busy_q, busy_d;
  logic [LenW-1:0]      idx_q, idx_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LabelW-1:0]    chars_q, chars_d;
  logic [BucketW-1:0]   h_q, h_d;
  logic [BucketW-1:0]   sum;

  assign sum    = h_q + chars_q[8*idx_q[2:0] +: 8];
  assign done_o = busy_q && (idx_q == len_q);
  assign hash_o = h_q;

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    len_d   = len_q;
    chars_d = chars_q;
    h_d     = h_q;
    if (start_i) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      len_d   = len_i;
      chars_d = chars_i;
      h_d     = '0;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      h_d   = BucketW'(sum * BucketW'(HashMul));
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    len_q   <= len_d;
    chars_q <= chars_d;
    h_q     <= h_d;
  end

endmodule

// ===== sv/ohm_entry_ram.sv =====
// entry store: label and value per slot, one write and one registered read port
module ohm_entry_ram #(
  parameter int AW = 11,
  parameter int DW = 68
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== sv/ohm_count_ram.sv =====
// per-bucket fill counts, valid bits make unwritten buckets read as empty
module ohm_count_ram #(
  parameter int CW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [ohm_pkg::BucketW-1:0] wr_addr_i,
  input  logic [CW-1:0]               wr_data_i,
  input  logic                        rd_en_i,
  input  logic [ohm_pkg::BucketW-1:0] rd_addr_i,
  output logic [CW-1:0]               rd_data_o
);
  import ohm_pkg::*;

  logic [CW-1:0]         mem [NumBuckets];
  logic [NumBuckets-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

endmodule

// ===== sv/ordered_bucket_hash_map.sv =====
// Insertion-ordered hash map of short labels, one bucket list per hash value.
// Input stream: each request is a remove (tuser 0) or an insert/update (tuser 1)
// of a label of up to eight bytes with a value. Output stream: one result per
// request with a status code in tuser and the bucket and weighted total in tdata.
// Per request the block hashes one label byte per cycle, reads the bucket count,
// then scans the bucket's slots in the entry memory one slot per cycle, shifting
// later slots down on a remove. The weighted total is kept exact and updated
// from the change in the one touched bucket, then saturated to 24 bits.
// Request time grows with label length and slots in use, set by the hash loop and
// the single read port of the entry memory. One request is handled at a time.
// tready is high only while the block is idle; a finished result sits in the
// output register, and the block takes the next request while it waits. When
// the receiver stalls, a second result is held back until the first is taken.
// After reset the map is empty and the total is zero; no clearing pass is needed.
module ordered_bucket_hash_map #(
  parameter int SLOTS_PER_BUCKET = 8,
  parameter int MAX_LABEL_CHARS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // label_chars, label_length, focal_value
  input  logic [ohm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func
  input  logic [ohm_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // bucket_index, weighted_total
  output logic [ohm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // status
  output logic [ohm_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import ohm_pkg::*;

  localparam int S    = SLOTS_PER_BUCKET;
  localparam int SW   = (S > 1) ? $clog2(S) : 1;
  localparam int CW   = $clog2(S + 1);
  localparam int AW   = BucketW + SW;
  localparam int EW   = LabelW + ValW;
  localparam int WMAX = ValMax * S * (S + 1) / 2;
  localparam int WW   = $clog2(WMAX + 1);
  localparam int DW   = WW + 1;
  localparam int PW   = DW + BucketW + 1;
  localparam int TW   = WW + 16;

  state_e state_q, state_d;

  // request fields
  func_e               func_q;
  logic [LabelW-1:0]   lbl_q, lbl_d;
  logic [LenW-1:0]     len_in, len_d;
  logic [ValW-1:0]     val_q;
  logic [BucketW-1:0]  bucket_q;

  // scan state
  logic [CW-1:0]       n_q, rp_q, dp_q, fpos_q;
  logic                dv_q, found_q;
  logic [ValW-1:0]     fval_q;
  logic [WW-1:0]       suf_q;
  logic signed [DW-1:0] delta_q, delta_d;
  logic signed [PW-1:0] prod_q;
  logic [TW-1:0]       total_q;
  status_e             status_q, status_d;

  // output register
  logic                out_valid_q;
  logic                out_load;
  status_e             out_status_q;
  logic [BucketW-1:0]  out_bucket_q;
  logic [TotalOutW-1:0] out_total_q;

  // submodule signals
  logic                hash_start, hash_done;
  logic [BucketW-1:0]  hash_val;
  logic                cnt_rd, cnt_wr;
  logic [CW-1:0]       cnt_wdata, cnt_rdata;
  logic                ent_rd, ent_wr;
  logic [AW-1:0]       ent_raddr, ent_waddr;
  logic [EW-1:0]       ent_wdata, ent_rdata;
  logic [LabelW-1:0]   ent_lbl;
  logic [ValW-1:0]     ent_val;
  logic                hit, shift_wr, append_ok;
  logic signed [TW:0]  total_sum;

  // clamp length and mask stray bytes
  assign len_in = s_axis_tdata_i[LabelW +: LenW];
  assign len_d  = (len_in > LenW'(MAX_LABEL_CHARS)) ? LenW'(MAX_LABEL_CHARS) : len_in;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lbl_d[8*i +: 8] = (LenW'(i) < len_d) ? s_axis_tdata_i[8*i +: 8] : 8'h00;
    end
  end

  ohm_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .chars_i (lbl_d),
    .len_i   (len_d),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  ohm_count_ram #(.CW(CW)) u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cnt_wr),
    .wr_addr_i (bucket_q),
    .wr_data_i (cnt_wdata),
    .rd_en_i   (cnt_rd),
    .rd_addr_i (hash_val),
    .rd_data_o (cnt_rdata)
  );

  ohm_entry_ram #(.AW(AW), .DW(EW)) u_entry (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr),
    .wr_addr_i (ent_waddr),
    .wr_data_i (ent_wdata),
    .rd_en_i   (ent_rd),
    .rd_addr_i (ent_raddr),
    .rd_data_o (ent_rdata)
  );

  assign ent_lbl   = ent_rdata[ValW +: LabelW];
  assign ent_val   = ent_rdata[ValW-1:0];
  assign hit       = dv_q && !found_q && (ent_lbl == lbl_q);
  assign shift_wr  = dv_q && found_q && (func_q == FuncRemove);
  assign append_ok = (n_q < CW'(S));
  assign out_load  = (state_q == SDone) && (!out_valid_q || m_axis_tready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (s_axis_tvalid_i) state_d = SHash;
      SHash:   if (hash_done) state_d = SCount;
      SCount:  state_d = SScan;
      SScan:   if ((rp_q == n_q) && !dv_q) state_d = SFinish;
      SFinish: state_d = SScale;
      SScale:  state_d = SDone;
      SDone:   if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    s_axis_tready_o = 1'b0;
    hash_start      = 1'b0;
    cnt_rd          = 1'b0;
    cnt_wr          = 1'b0;
    cnt_wdata       = n_q;
    ent_rd          = 1'b0;
    ent_raddr       = {bucket_q, rp_q[SW-1:0]};
    ent_wr          = 1'b0;
    ent_waddr       = {bucket_q, dp_q[SW-1:0] - 1'b1};
    ent_wdata       = ent_rdata;
    case (state_q)
      SIdle: begin
        s_axis_tready_o = 1'b1;
        hash_start      = s_axis_tvalid_i;
      end
      SHash: begin
        cnt_rd = hash_done;
      end
      SScan: begin
        ent_rd = (rp_q < n_q);
        ent_wr = shift_wr;
      end
      SFinish: begin
        ent_wdata = {lbl_q, val_q};
        if (func_q == FuncRemove) begin
          cnt_wr    = found_q;
          cnt_wdata = n_q - 1'b1;
        end else if (found_q) begin
          ent_wr    = 1'b1;
          ent_waddr = {bucket_q, fpos_q[SW-1:0]};
        end else if (append_ok) begin
          ent_wr    = 1'b1;
          ent_waddr = {bucket_q, n_q[SW-1:0]};
          cnt_wr    = 1'b1;
          cnt_wdata = n_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // change of the bucket's weight for this request
  always_comb begin
    logic signed [DW-1:0] fp1, nvs, vdiff, rm;
    fp1     = DW'($signed({1'b0, fpos_q} + 1'b1));
    nvs     = DW'($signed({1'b0, n_q} + 1'b1));
    vdiff   = DW'($signed({1'b0, val_q})) - DW'($signed({1'b0, fval_q}));
    rm      = fp1 * DW'($signed({1'b0, fval_q})) + DW'($signed({1'b0, suf_q}));
    delta_d = '0;
    if (func_q == FuncRemove) begin
      status_d = found_q ? StRemoved : StNotFound;
      if (found_q) delta_d = -rm;
    end else if (found_q) begin
      status_d = StUpdated;
      delta_d  = fp1 * vdiff;
    end else if (append_ok) begin
      status_d = StAppended;
      delta_d  = nvs * DW'($signed({1'b0, val_q}));
    end else begin
      status_d = StBucketFull;
    end
  end

  assign total_sum = $signed({1'b0, total_q}) + (TW+1)'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        total_q     <= total_sum[TW-1:0];
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SCount: begin
          dv_q    <= 1'b0;
          found_q <= 1'b0;
        end
        SScan: begin
          dv_q <= (rp_q < n_q);
          if (hit) found_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        func_q <= func_e'(s_axis_tuser_i[0]);
        lbl_q  <= lbl_d;
        val_q  <= s_axis_tdata_i[LabelW+LenW +: ValW];
      end
      SHash: begin
        bucket_q <= hash_val;
      end
      SCount: begin
        n_q    <= cnt_rdata;
        rp_q   <= '0;
        suf_q  <= '0;
      end
      SScan: begin
        if (rp_q < n_q) begin
          dp_q <= rp_q;
          rp_q <= rp_q + 1'b1;
        end
        if (dv_q) begin
          if (hit) begin
            fpos_q <= dp_q;
            fval_q <= ent_val;
          end else if (found_q) begin
            suf_q <= suf_q + WW'(ent_val);
          end
        end
      end
      SFinish: begin
        delta_q  <= delta_d;
        status_q <= status_d;
      end
      SScale: begin
        // bucket + 1 reaches 256, so it needs a tenth bit to stay positive
        prod_q <= PW'(delta_q) * PW'($signed({2'b00, bucket_q} + 1'b1));
      end
      SDone: begin
        if (out_load) begin
          out_status_q <= status_q;
          out_bucket_q <= bucket_q;
          out_total_q  <= (total_sum[TW-1:0] > TW'(2**TotalOutW - 1)) ?
                          '1 : total_sum[TotalOutW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_total_q, out_bucket_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ===== sv/ohm_checker.sv =====
// port-level checks for the ordered bucket hash map
module ohm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [ohm_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic [ohm_pkg::InUserW-1:0]   s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ohm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [ohm_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import ohm_pkg::*;

  logic unused_in;
  assign unused_in = ^{s_axis_tdata_i, s_axis_tuser_i, m_axis_tdata_o};

  // a result waiting on the receiver stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while busy");

  // a new result only comes out of a request in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without request in progress");

  // status code stays within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == StAppended || m_axis_tuser_o == StUpdated ||
                         m_axis_tuser_o == StRemoved || m_axis_tuser_o == StNotFound ||
                         m_axis_tuser_o == StBucketFull))
    else $error("undefined status code");

endmodule

bind ordered_bucket_hash_map ohm_checker u_ohm_checker (.*);
